// ===== hdl/aes_pkg.sv =====
`default_nettype none
// Shared types, constants and GF(2^8) helpers for the AES-128 round pipeline.
package aes_pkg;

    localparam int NUM_ROUNDS  = 10;
    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;

    localparam logic [HALF_W-1:0] KEY_HIGH_RESET = 64'h0F1571C947D9E859;
    localparam logic [HALF_W-1:0] KEY_LOW_RESET  = 64'h0CB7ADD6AF7F6798;

    localparam logic [7:0] GF_POLY = 8'h1B;

    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic [BLOCK_W-1:0] rkey;
    } aes_data_t;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // column bytes a0..a3 from the most significant end
    function automatic logic [31:0] mix_column(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        d0 = xtime(a0);
        d1 = xtime(a1);
        d2 = xtime(a2);
        d3 = xtime(a3);
        return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                a0 ^ d1 ^ d2 ^ a2 ^ a3,
                a0 ^ a1 ^ d2 ^ d3 ^ a3,
                d0 ^ a0 ^ a1 ^ a2 ^ d3};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_round_cell.sv =====
`default_nettype none
// One AES round cell: expands its round key and applies one cipher round.
module aes_round_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        rcon,
    input  wire logic              last_round,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire aes_pkg::aes_data_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output aes_pkg::aes_data_t     out_data
);

    logic               valid_reg;
    aes_pkg::aes_data_t data_reg;
    aes_pkg::aes_data_t data_next;

    logic [7:0]   s_byte [16];
    logic [7:0]   t_byte [16];
    logic [127:0] shifted;
    logic [127:0] mixed;
    logic [31:0]  w0, w1, w2, w3, t, w4, w5, w6, w7;

    always_comb begin
        w0 = in_data.rkey[127:96];
        w1 = in_data.rkey[95:64];
        w2 = in_data.rkey[63:32];
        w3 = in_data.rkey[31:0];
        t  = aes_pkg::sub_word({w3[23:0], w3[31:24]}) ^ {rcon, 24'h000000};
        w4 = w0 ^ t;
        w5 = w1 ^ w4;
        w6 = w2 ^ w5;
        w7 = w3 ^ w6;
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            s_byte[k] = in_data.state[127 - 8 * k -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t_byte[4 * c + r] = aes_pkg::SBOX[s_byte[4 * ((c + r) & 3) + r]];
            end
        end
        for (int k = 0; k < 16; k++) begin
            shifted[127 - 8 * k -: 8] = t_byte[k];
        end
        for (int c = 0; c < 4; c++) begin
            mixed[127 - 32 * c -: 32] = aes_pkg::mix_column(shifted[127 - 32 * c -: 32]);
        end
        data_next.rkey  = {w4, w5, w6, w7};
        data_next.state = (last_round ? shifted : mixed) ^ {w4, w5, w6, w7};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted word did not reach the cell register");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled word was lost or changed");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg && !in_valid |=> !valid_reg)
        else $error("cell became valid without an input word");

endmodule
`default_nettype wire

// ===== hdl/aes128_block_encrypt.sv =====
`default_nettype none
// AES-128 encryption pipeline: key registers, initial key add and ten round cells.
//
//   channel | ports                    | contents
//   --------+--------------------------+-------------------------------------
//   input   | s_tvalid/s_tready/s_tdata| plain_high [63:0], plain_low [127:64]
//   output  | m_tvalid/m_tready/m_tdata| cipher_high [63:0], cipher_low [127:64]
//   config  | cfg_wr_en/index/wdata    | 0 key_high, 1 key_low
//
// One word per cycle sustained while m_tready is high; each word passes the input
// key-add register and then one register per round cell (ten cells).
// Each round key is computed in its cell from the previous one and travels with the word.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default key.
// A stalled output holds the last cell; earlier cells keep filling empty slots.
module aes128_block_encrypt (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [127:0]                    s_tdata,  // plain_high, plain_low
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [127:0]                         m_tdata,  // cipher_high, cipher_low
    input  wire logic                            cfg_wr_en,
    input  wire logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                     cfg_wdata
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;

    logic               chain_valid [aes_pkg::NUM_ROUNDS+1];
    logic               chain_ready [aes_pkg::NUM_ROUNDS+1];
    aes_pkg::aes_data_t chain_data  [aes_pkg::NUM_ROUNDS+1];

    logic               in_valid_reg;
    aes_pkg::aes_data_t in_data_reg;
    aes_pkg::aes_data_t in_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= aes_pkg::KEY_HIGH_RESET;
            key_low_reg  <= aes_pkg::KEY_LOW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_data_next.rkey  = {key_high_reg, key_low_reg};
        in_data_next.state = {s_tdata[63:0], s_tdata[127:64]} ^ {key_high_reg, key_low_reg};
    end

    assign s_tready = !in_valid_reg || chain_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= in_data_next;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    for (genvar g = 0; g < aes_pkg::NUM_ROUNDS; g++) begin : g_round
        aes_round_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .rcon       (aes_pkg::RCON[g]),
            .last_round (g == aes_pkg::NUM_ROUNDS - 1),
            .in_valid   (chain_valid[g]),
            .in_ready   (chain_ready[g]),
            .in_data    (chain_data[g]),
            .out_valid  (chain_valid[g+1]),
            .out_ready  (chain_ready[g+1]),
            .out_data   (chain_data[g+1])
        );
    end

    assign chain_ready[aes_pkg::NUM_ROUNDS] = m_tready;
    assign m_tvalid = chain_valid[aes_pkg::NUM_ROUNDS];
    assign m_tdata  = {chain_data[aes_pkg::NUM_ROUNDS].state[63:0],
                       chain_data[aes_pkg::NUM_ROUNDS].state[127:64]};

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the AES-128 block encryption pipeline.
module tb_top;

    localparam int PIPE_LATENCY = 11;
    localparam int PHASE_WORDS  = 475;

    localparam logic [aes_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [aes_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [127:0]                    s_tdata;   // plain_high [63:0], plain_low [127:64]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [127:0]                    m_tdata;   // cipher_high [63:0], cipher_low [127:64]
    logic                            cfg_wr_en;
    logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]                     cfg_wdata;

    logic [7:0]  sbox_tab [256];
    logic [63:0] key_hi_model;
    logic [63:0] key_lo_model;
    cipher_t     pending_cipher [$];
    int          fail_count     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    aes128_block_encrypt u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return (b << 1) ^ (8'h1B & {8{b[7]}});
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // multiplicative inverse (a^254) followed by the affine map
    function automatic logic [7:0] sbox_entry(input logic [7:0] a);
        logic [7:0] inv, base;
        inv  = 8'h01;
        base = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) inv = gf_mul(inv, base);
            base = gf_mul(base, base);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // byte 0 of key, plaintext and result sits in bits 127:120
    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] plain);
        logic [31:0]  w [44];
        logic [7:0]   st [16];
        logic [7:0]   nx [16];
        logic [31:0]  t;
        logic [7:0]   rc, a0, a1, a2, a3;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sbox_tab[t[31:24]], sbox_tab[t[23:16]], sbox_tab[t[15:8]],
                     sbox_tab[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int k = 0; k < 16; k++)
            st[k] = plain[127 - 8*k -: 8] ^ w[k/4][31 - 8*(k%4) -: 8];
        for (int rnd = 1; rnd <= aes_pkg::NUM_ROUNDS; rnd++) begin
            for (int k = 0; k < 16; k++)
                nx[k] = sbox_tab[st[4*((k/4 + k%4) % 4) + k%4]];
            if (rnd != aes_pkg::NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = nx[4*c];
                    a1 = nx[4*c+1];
                    a2 = nx[4*c+2];
                    a3 = nx[4*c+3];
                    nx[4*c]   = gf_mul(8'h02, a0) ^ gf_mul(8'h03, a1) ^ a2 ^ a3;
                    nx[4*c+1] = a0 ^ gf_mul(8'h02, a1) ^ gf_mul(8'h03, a2) ^ a3;
                    nx[4*c+2] = a0 ^ a1 ^ gf_mul(8'h02, a2) ^ gf_mul(8'h03, a3);
                    nx[4*c+3] = gf_mul(8'h03, a0) ^ a1 ^ a2 ^ gf_mul(8'h02, a3);
                end
            end
            for (int k = 0; k < 16; k++)
                st[k] = nx[k] ^ w[4*rnd + k/4][31 - 8*(k%4) -: 8];
        end
        for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = st[k];
        return res;
    endfunction

    function automatic logic [127:0] random_plain();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0: v = 128'(v[7:0]) << (8 * $urandom_range(15));
            1: v = 128'd1 << $urandom_range(127);
            2: v = ~(128'd1 << $urandom_range(127));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_plain(input logic [63:0] hi, input logic [63:0] lo);
        logic         taken;
        logic [127:0] c;
        cipher_t      want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        c = encrypt_block({key_hi_model, key_lo_model}, {hi, lo});
        want.hi = c[127:64];
        want.lo = c[63:0];
        pending_cipher.push_back(want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cipher.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [aes_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == aes_pkg::REG_KEY_HIGH) key_hi_model = val;
        else if (idx == aes_pkg::REG_KEY_LOW) key_lo_model = val;
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        write_reg(aes_pkg::REG_KEY_HIGH, hi);
        write_reg(aes_pkg::REG_KEY_LOW, lo);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // word is taken at the next rising edge; outputs are stable here
    always @(negedge aclk) begin
        cipher_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_cipher.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected word %h", $realtime, m_tdata);
            end else begin
                want = pending_cipher.pop_front();
                compare_field("cipher_high", want.hi, m_tdata[63:0]);
                compare_field("cipher_low", want.lo, m_tdata[127:64]);
            end
        end
    end

    task automatic test_default_key();
        send_plain(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        send_plain(64'h0, 64'h0);
        send_plain('1, '1);
        drain_results();
    endtask

    task automatic test_known_vector();
        load_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
        if (encrypt_block({key_hi_model, key_lo_model},
                          128'h00112233445566778899AABBCCDDEEFF)
                !== 128'h69C4E0D86A7B0430D8CDB78070B4C55A) begin
            fail_count++;
            $display("%0t: predictor disagrees with the published vector", $realtime);
        end
        send_plain(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
        drain_results();
    endtask

    task automatic test_plain_extremes();
        send_plain(64'h0, 64'h0);
        send_plain('1, '1);
        send_plain(64'h8000000000000000, 64'h0);
        send_plain(64'h0, 64'h1);
        send_plain(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
        drain_results();
    endtask

    task automatic test_spare_index();
        logic [127:0] v;
        write_reg(REG_SPARE_2, {$urandom, $urandom});
        write_reg(REG_SPARE_3, {$urandom, $urandom});
        repeat (2) begin
            v = random_plain();
            send_plain(v[127:64], v[63:0]);
        end
        drain_results();
    endtask

    task automatic test_key_extremes();
        load_key(64'h0, 64'h0);
        send_plain(64'h0, 64'h0);
        send_plain('1, '1);
        drain_results();
        load_key('1, '1);
        send_plain(64'h0, 64'h0);
        send_plain('1, '1);
        drain_results();
        write_reg(aes_pkg::REG_KEY_HIGH, 64'h0);
        send_plain(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        drain_results();
        write_reg(aes_pkg::REG_KEY_LOW, 64'h8000000000000001);
        send_plain(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        drain_results();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        logic [127:0] v;
        drain_results();
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_WORDS; i++) begin
            // hold off until the pipeline is empty
            if (i == PHASE_WORDS / 2) drain_results();
            v = random_plain();
            send_plain(v[127:64], v[63:0]);
        end
        drain_results();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= aes_pkg::REG_KEY_HIGH;
        cfg_wdata <= '0;
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_entry(8'(i));
        key_hi_model = aes_pkg::KEY_HIGH_RESET;
        key_lo_model = aes_pkg::KEY_LOW_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_key();
        test_known_vector();
        test_plain_extremes();
        test_spare_index();
        test_key_extremes();
        test_random_phase(0, 0);
        test_random_phase(69, 0);
        test_random_phase(0, 69);
        test_random_phase(29, 29);

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
